### hw/rtl/set_assoc_lru_cache_lookup_defines.svh
// Assertion macros for the cache lookup block.
// Taken in by the files that carry concurrent checks; needs nothing else.
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_DEFINES_SVH

// general form: explicit clock and reset
`define SALC_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// usual form inside this block: clock and reset named as in the checked modules
`define SALC_ASSERT(lbl, prop, msg) \
   `SALC_ASSERT_CLK(lbl, clock, reset, prop, msg)

`endif

### hw/rtl/salc_pkg.sv
// Shared constants and control types of the cache lookup block.
// No dependencies; used by the interfaces and all modules except salc_ram.
package salc_pkg;

   localparam int SETS_DEFAULT = 64;
   localparam int WAYS_DEFAULT = 8;

   localparam int ADDR_W      = 32;
   localparam int CNT_W       = 32;
   localparam int WAY_OUT_W   = 3;
   localparam int SET_BITS_W  = 3;
   localparam int BLK_BITS_W  = 5;
   localparam int WAYS_REG_W  = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WAYS       = 2'd2;

   localparam logic [SET_BITS_W-1:0] SET_BITS_RESET   = 3'd6;
   localparam logic [BLK_BITS_W-1:0] BLOCK_BITS_RESET = 5'd2;
   localparam logic [WAYS_REG_W-1:0] WAYS_RESET       = 4'd8;

   typedef struct packed {
      logic clear;    // write an empty row during the sweep
      logic accept;   // take the request beat, read its set
      logic lookup;   // compare and pick the way
      logic commit;   // write back the row, load the response
   } salc_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_free;
   } salc_stat_type;

endpackage

### hw/rtl/salc_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on salc_pkg for the field widths.
interface salc_req_if import salc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink   (input valid, input address, output ready);
endinterface

interface salc_rsp_if import salc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [WAY_OUT_W-1:0] way_used;
   logic [CNT_W-1:0]     access_count;
   logic [CNT_W-1:0]     miss_count;

   modport source (output valid, output hit, output way_used, output access_count,
                   output miss_count, input ready);
   modport sink   (input valid, input hit, input way_used, input access_count,
                   input miss_count, output ready);
endinterface

### hw/rtl/salc_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/salc_ctrl.sv
// Sequencer of the cache lookup: clear sweep, accept, lookup, commit.
// Depends on salc_pkg and the assertion macro header.
`include "set_assoc_lru_cache_lookup_defines.svh"

module salc_ctrl import salc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  salc_stat_type stat,
   output salc_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               if (stat.clear_last) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_LOOKUP;
                  ready_ff <= 1'b0;
               end
            end
            ST_LOOKUP: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               // hold until the response register can take the result
               if (stat.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
               ready_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_ready  = ready_ff;
   assign cmd.clear  = (state_ff == ST_CLEAR);
   assign cmd.accept = ready_ff && req_valid;
   assign cmd.lookup = (state_ff == ST_LOOKUP);
   assign cmd.commit = (state_ff == ST_COMMIT) && stat.out_free;

   `SALC_ASSERT(a_ready_only_idle, ready_ff |-> (state_ff == ST_IDLE), "ready outside idle")
   `SALC_ASSERT(a_accept_to_lookup, cmd.accept |=> (state_ff == ST_LOOKUP), "beat not looked up")

endmodule

### hw/rtl/salc_dpath.sv
// Datapath of the cache lookup: config registers, address split, tag RAM,
// way selection, LRU rank update, counters and the response register.
// Depends on salc_pkg, salc_ram, salc_rsp_if and the assertion macro header.
`include "set_assoc_lru_cache_lookup_defines.svh"

module salc_dpath import salc_pkg::*; #(
   parameter int SETS = SETS_DEFAULT,
   parameter int WAYS = WAYS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  salc_cmd_type           cmd,
   output salc_stat_type          stat,
   input  logic [ADDR_W-1:0]      req_address,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   salc_rsp_if.source             rsp
);

   localparam int SETW  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAYW  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANKW = WAYW;
   localparam int NW    = $clog2(WAYS + 1);
   localparam int PW    = 1 << WAYW;
   localparam int RAW_W = 7;                // set field before folding
   localparam int FOLDN = 1 << RAW_W;

   typedef struct packed {
      logic             valid;
      logic [RANKW-1:0] rank;
      logic [ADDR_W-1:0] tag;
   } way_type;

   localparam int ROWW = WAYS * $bits(way_type);

   // configuration
   logic [SET_BITS_W-1:0] set_bits_ff;
   logic [BLK_BITS_W-1:0] block_bits_ff;
   logic [WAYS_REG_W-1:0] ways_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= SET_BITS_RESET;
         block_bits_ff <= BLOCK_BITS_RESET;
         ways_ff       <= WAYS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_wdata[SET_BITS_W-1:0];
            CSR_BLOCK_BITS: block_bits_ff <= csr_wdata;
            CSR_WAYS:       ways_ff       <= csr_wdata[WAYS_REG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ways searched, clamped to 1..WAYS
   logic [4:0]      ways_wide;
   logic [NW-1:0]   n_ways;
   logic [WAYS-1:0] srch;

   always_comb begin
      ways_wide = {1'b0, ways_ff};
      if (ways_wide == 5'd0) begin
         n_ways = NW'(1);
      end else if (ways_wide > 5'(WAYS)) begin
         n_ways = NW'(WAYS);
      end else begin
         n_ways = NW'(ways_wide);
      end
      for (int w = 0; w < WAYS; w++) begin
         srch[w] = (NW'(w) < n_ways);
      end
   end

   // set index fold modulo SETS, one entry per raw field value
   logic [SETW-1:0] fold_tab [FOLDN];

   for (genvar g = 0; g < FOLDN; g++) begin : g_fold
      assign fold_tab[g] = SETW'(g % SETS);
   end

   logic [ADDR_W-1:0] off_addr;
   logic [7:0]        set_mask;
   logic [RAW_W-1:0]  raw_set;
   logic [SETW-1:0]   set_idx;
   logic [5:0]        tot_sh;
   logic [ADDR_W-1:0] tag_val;

   always_comb begin
      off_addr = req_address >> block_bits_ff;
      set_mask = (8'd1 << set_bits_ff) - 8'd1;
      raw_set  = off_addr[RAW_W-1:0] & set_mask[RAW_W-1:0];
      set_idx  = fold_tab[raw_set];
      tot_sh   = 6'(block_bits_ff) + 6'(set_bits_ff);
      // a shift of 32 or more leaves no tag bits
      tag_val  = tot_sh[5] ? '0 : (req_address >> tot_sh[4:0]);
   end

   logic [SETW-1:0]   set_ff;
   logic [ADDR_W-1:0] tag_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         set_ff <= set_idx;
         tag_ff <= tag_val;
      end
   end

   // clear sweep counter
   logic [SETW-1:0] clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign stat.clear_last = (clr_cnt_ff == SETW'(SETS - 1));

   // tag RAM, one row per set
   logic [ROWW-1:0]          rd_row;
   way_type [WAYS-1:0]       row;
   way_type [WAYS-1:0]       new_row;
   logic                     ram_we;
   logic [SETW-1:0]          ram_waddr;
   logic [ROWW-1:0]          ram_wdata;

   assign ram_we    = cmd.clear || cmd.commit;
   assign ram_waddr = cmd.clear ? clr_cnt_ff : set_ff;
   assign ram_wdata = cmd.clear ? '0 : new_row;

   salc_ram #(
      .WIDTH (ROWW),
      .DEPTH (SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (set_idx),
      .rd_data (rd_row)
   );

   assign row = rd_row;

   // lookup: hit search, first free way, LRU victim tree
   logic [WAYS-1:0]  hit_vec;
   logic [WAYS-1:0]  inv_vec;
   logic [WAYW-1:0]  hit_idx;
   logic [WAYW-1:0]  inv_idx;
   logic [RANKW:0]   key [PW];
   logic [WAYW-1:0]  kidx [PW];
   logic [WAYW-1:0]  chosen_in;

   always_comb begin
      hit_idx = '0;
      inv_idx = '0;
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w] = srch[w] && row[w].valid && (row[w].tag == tag_ff);
         inv_vec[w] = srch[w] && !row[w].valid;
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_idx = WAYW'(w);
         end
         if (inv_vec[w]) begin
            inv_idx = WAYW'(w);
         end
      end
      for (int i = 0; i < PW; i++) begin
         key[i]  = '0;
         kidx[i] = WAYW'(i);
      end
      for (int i = 0; i < WAYS; i++) begin
         if (srch[i]) begin
            key[i] = {1'b1, row[i].rank};
         end
      end
      // pairwise max, the lower way wins a tie
      for (int s = 1; s < PW; s = s * 2) begin
         for (int i = 0; i < PW; i = i + 2 * s) begin
            if (key[i + s] > key[i]) begin
               key[i]  = key[i + s];
               kidx[i] = kidx[i + s];
            end
         end
      end
      if (|hit_vec) begin
         chosen_in = hit_idx;
      end else if (|inv_vec) begin
         chosen_in = inv_idx;
      end else begin
         chosen_in = kidx[0];
      end
   end

   logic            hit_ff;
   logic [WAYW-1:0] chosen_ff;

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hit_ff    <= |hit_vec;
         chosen_ff <= chosen_in;
      end
   end

   // commit: age the younger ways, chosen way becomes most recent
   way_type       cw;
   logic [NW-1:0] r_lim;

   always_comb begin
      cw      = row[chosen_ff];
      r_lim   = cw.valid ? NW'(cw.rank) : n_ways;
      new_row = row;
      for (int w = 0; w < WAYS; w++) begin
         if (srch[w] && row[w].valid && (WAYW'(w) != chosen_ff) &&
             (NW'(row[w].rank) < r_lim) && (row[w].rank < RANKW'(WAYS - 1))) begin
            new_row[w].rank = row[w].rank + 1'b1;
         end
      end
      new_row[chosen_ff].valid = 1'b1;
      new_row[chosen_ff].rank  = '0;
      new_row[chosen_ff].tag   = tag_ff;
   end

   // counters double as the response count fields: they only move on commit,
   // and commit waits until the previous response has gone
   logic [CNT_W-1:0] acc_cnt_ff;
   logic [CNT_W-1:0] miss_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_cnt_ff  <= '0;
         miss_cnt_ff <= '0;
      end else if (cmd.commit) begin
         if (acc_cnt_ff != '1) begin
            acc_cnt_ff <= acc_cnt_ff + 1'b1;
         end
         if (!hit_ff && (miss_cnt_ff != '1)) begin
            miss_cnt_ff <= miss_cnt_ff + 1'b1;
         end
      end
   end

   // response register
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [WAY_OUT_W-1:0] rsp_way_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff <= hit_ff;
         rsp_way_ff <= WAY_OUT_W'(chosen_ff);
      end
   end

   assign stat.out_free    = !rsp_valid_ff || rsp.ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.hit          = rsp_hit_ff;
   assign rsp.way_used     = rsp_way_ff;
   assign rsp.access_count = acc_cnt_ff;
   assign rsp.miss_count   = miss_cnt_ff;

   `SALC_ASSERT(a_miss_le_acc, miss_cnt_ff <= acc_cnt_ff, "miss count above access count")
   `SALC_ASSERT(a_chosen_searched, cmd.commit |-> (NW'(chosen_ff) < n_ways), "chosen way not searched")
   `SALC_ASSERT(a_commit_shows_rsp, cmd.commit |=> rsp_valid_ff, "committed result not presented")

endmodule

### hw/rtl/set_assoc_lru_cache_lookup.sv
// Channel   Dir  Payload
// req       in   address[31:0]
// rsp       out  hit, way_used[2:0], access_count[31:0], miss_count[31:0]
// csr_*     in   write enable, index[1:0], data[4:0]
//
// Each request passes through the set read from the tag RAM, the way compare and
// victim pick, then the read-modify-write of the set row through its one write port.
// After reset a clearing pass writes every set row before the first request
// beat is taken; csr writes are taken throughout.
// A result waits in the response register while the next beat is taken; the
// commit of that next beat stalls until the waiting response is taken.
//
// Top level of the set-associative LRU cache lookup.
// Depends on salc_pkg, salc_if, salc_ctrl and salc_dpath.
module set_assoc_lru_cache_lookup import salc_pkg::*; #(
   parameter int SETS = SETS_DEFAULT,
   parameter int WAYS = WAYS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   salc_req_if.sink               req,
   salc_rsp_if.source             rsp,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   salc_cmd_type  cmd;
   salc_stat_type stat;

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   salc_dpath #(
      .SETS (SETS),
      .WAYS (WAYS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_address (req.address),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp         (rsp)
   );

endmodule
